FILE: design/sfbs_pkg.sv
// ----------------------------------------------------------------------------
// sfbs_pkg: shared types and constants
// sizes, payload structs and register indexes for the box suppression block
// ----------------------------------------------------------------------------
package sfbs_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 12;
  localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
  localparam int AREA_BITS  = 2 * COORD_BITS;

  localparam logic [15:0] SCORE_LIMIT_RST   = 16'd45875;
  localparam logic [15:0] OVERLAP_LIMIT_RST = 16'd19661;

  localparam logic [1:0] REG_SCORE_LIMIT   = 2'd0;
  localparam logic [1:0] REG_OVERLAP_LIMIT = 2'd1;

  typedef struct packed {
    logic [COORD_BITS-1:0] left_edge;
    logic [COORD_BITS-1:0] top_edge;
    logic [COORD_BITS-1:0] right_edge;
    logic [COORD_BITS-1:0] bottom_edge;
    logic [15:0]           box_score;
    logic                  final_box;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] kept_left;
    logic [COORD_BITS-1:0] kept_top;
    logic [COORD_BITS-1:0] kept_right;
    logic [COORD_BITS-1:0] kept_bottom;
    logic [15:0]           kept_score;
    logic                  run_end;
    logic                  none_kept;
    logic                  capacity_lost;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y2;
    logic [15:0]           sc;
  } box_t;

  // per-cell control broadcast from the sequencer
  typedef struct packed {
    logic insert;   // new box travels into the chain
    logic shift;    // rotate chain by one cell toward head
    logic clear;    // frame end: empty chain
  } cell_ctl_t;

  function automatic logic [COORD_BITS-1:0] ext(input logic [COORD_BITS-1:0] lo,
                                                 input logic [COORD_BITS-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  // area of a box, zero along an inverted axis
  function automatic logic [AREA_BITS-1:0] span_area(input logic [COORD_BITS-1:0] x1,
                                                     input logic [COORD_BITS-1:0] y1,
                                                     input logic [COORD_BITS-1:0] x2,
                                                     input logic [COORD_BITS-1:0] y2);
    logic [AREA_BITS-1:0] w, h;
    w = {{(AREA_BITS-COORD_BITS){1'b0}}, ext(x1, x2)};
    h = {{(AREA_BITS-COORD_BITS){1'b0}}, ext(y1, y2)};
    return w * h;
  endfunction

endpackage

FILE: design/score_filter_box_suppression.sv
// a non-final transfer is sorted into the cell chain at its accepting edge
// and the input stalls in the cycle after it, so boxes are not taken back to back
// final transfer: the pick state steps through the store positions; per kept box the
// chain rotates the rest of a full turn, waiting on the overlap test for each
// undecided box tested, then loads its result; an empty frame passes through the rest and empty states to its result
// reset: chain and frame state cleared, score and overlap limits at their defaults
// ----------------------------------------------------------------------------
// score_filter_box_suppression: greedy non-maximum suppression
// boxes at or above the score limit are sorted into a chain of cells on arrival, then suppressed greedily
// ----------------------------------------------------------------------------
module score_filter_box_suppression
  import sfbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_LOAD, S_REST, S_PICK, S_SCAN, S_EMIT, S_EMPTY, S_CLEAR
  } state_t;

  state_t state;
  logic [15:0] score_limit, overlap_limit;
  logic [CNT_BITS-1:0] count;        // boxes in chain
  logic [CNT_BITS-1:0] done;         // store position now at the head
  logic [CNT_BITS-1:0] steps;        // rotations in current scan
  logic [2:0]          drain;        // cycles waited on the overlap pipeline
  logic                overflow, any_kept, final_pend;
  logic                survivor;     // an undecided box outlived the current scan
  box_t                ref_box, new_box, cand;
  cell_ctl_t           ctl;
  logic                in_take, head_live, pick_done, scan_last;
  logic                hit, hit_tail;

  box_t  cbox [MAX_BOXES];
  logic  cvld [MAX_BOXES];
  logic  csup [MAX_BOXES];
  logic  ctak [MAX_BOXES];

  // input waits while the pass runs or a result is still pending
  assign in_stall = (state != S_LOAD) || out_valid;
  assign in_take  = in_valid && !in_stall;
  assign new_box  = '{x1: in_data.left_edge, y1: in_data.top_edge,
                      x2: in_data.right_edge, y2: in_data.bottom_edge,
                      sc: in_data.box_score};

  // head of the chain is the box under test; live means stored and undecided
  assign cand      = cbox[0];
  assign head_live = cvld[0] && !csup[0];
  assign pick_done = (done == count);
  assign scan_last = (steps == CNT_BITS'(MAX_BOXES - 2));

  always_comb begin
    ctl = '0;
    ctl.insert = in_take
                 && (in_data.box_score >= score_limit)
                 && (count < CNT_BITS'(MAX_BOXES));
    // pick: always step past the head; scan: step at once past decided or
    // empty cells, otherwise after the overlap test has settled
    ctl.shift  = ((state == S_PICK) && !pick_done)
                 || ((state == S_SCAN) && (!head_live || drain == 3'd4));
    ctl.clear  = (state == S_CLEAR);
  end

  // head box goes to the tail marked: a kept box on pick, an overlapping box
  // during the scan
  assign hit_tail = ((state == S_PICK) && head_live)
                    || ((state == S_SCAN) && head_live && hit);

  // chain rotates toward the head; head box leaves to the tail
  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    localparam int NX = (g == MAX_BOXES - 1) ? 0 : g + 1;
    localparam int PV = (g == 0) ? 0 : g - 1;
    logic tail_hit;
    assign tail_hit = (g == MAX_BOXES - 1) ? hit_tail : 1'b0;
    sfbs_cell u_cell (
      .clk, .rst, .ctl,
      .new_box,
      .prev_takes (g == 0 ? 1'b0 : ctak[PV]),
      .prev_box   (cbox[PV]),
      .prev_vld   (g == 0 ? 1'b0 : cvld[PV]),
      .next_box   (cbox[NX]),
      .next_vld   (cvld[NX]),
      .next_sup   (csup[NX]),
      .sup_hit    (tail_hit),
      .takes      (ctak[g]),
      .box        (cbox[g]),
      .vld        (cvld[g]),
      .sup        (csup[g])
    );
  end

  sfbs_iou u_iou (
    .clk, .ref_box, .cand, .overlap_limit, .hit
  );

  // pass: each kept head becomes the reference, then the chain makes the rest
  // of a full turn so every undecided box meets it at the head; a full turn
  // brings the kept box back to the head, already marked
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      score_limit   <= SCORE_LIMIT_RST;
      overlap_limit <= OVERLAP_LIMIT_RST;
      count         <= '0;
      overflow      <= 1'b0;
      out_valid     <= 1'b0;
      out_data      <= '0;
      any_kept      <= 1'b0;
      done          <= '0;
      steps         <= '0;
      drain         <= '0;
      survivor      <= 1'b0;
      final_pend    <= 1'b0;
      ref_box       <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_SCORE_LIMIT)   score_limit   <= cfg_data;
      if (cfg_we && cfg_index == REG_OVERLAP_LIMIT) overlap_limit <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (in_take) begin
            if (in_data.box_score >= score_limit) begin
              if (count < CNT_BITS'(MAX_BOXES)) count <= count + 1'b1;
              else overflow <= 1'b1;
            end
            final_pend <= in_data.final_box;
            state <= S_REST;
          end
        end
        S_REST: begin
          done <= '0;
          any_kept <= 1'b0;
          if (!final_pend) state <= S_LOAD;
          else if (count == '0) state <= S_EMPTY;
          else state <= S_PICK;
        end
        S_PICK: begin
          if (pick_done) begin
            state <= any_kept ? S_CLEAR : S_EMPTY;
          end else if (head_live) begin
            // first undecided box is always kept
            ref_box  <= cand;
            survivor <= 1'b0;
            steps    <= '0;
            drain    <= '0;
            state    <= S_SCAN;
          end else begin
            done <= done + 1'b1;
          end
        end
        S_SCAN: begin
          if (ctl.shift) begin
            drain <= '0;
            if (head_live && !hit) survivor <= 1'b1;
            steps <= steps + 1'b1;
            if (scan_last) state <= S_EMIT;
          end else begin
            drain <= drain + 1'b1;
          end
        end
        S_EMIT: begin
          // last kept box when nothing outlived its scan
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data  <= '{kept_left: ref_box.x1, kept_top: ref_box.y1,
                           kept_right: ref_box.x2, kept_bottom: ref_box.y2,
                           kept_score: ref_box.sc, run_end: !survivor,
                           none_kept: 1'b0, capacity_lost: overflow};
            any_kept  <= 1'b1;
            state     <= S_PICK;
          end
        end
        S_EMPTY: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data  <= '{kept_left: '0, kept_top: '0, kept_right: '0,
                           kept_bottom: '0, kept_score: '0, run_end: 1'b1,
                           none_kept: 1'b1, capacity_lost: overflow};
            state     <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          count    <= '0;
          overflow <= 1'b0;
          state    <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: design/sfbs_cell.sv
// ----------------------------------------------------------------------------
// sfbs_cell: one slot of the sorted box chain
// holds a box and its valid and suppressed marks; sorted insert and rotation
// ----------------------------------------------------------------------------
module sfbs_cell
  import sfbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  box_t      new_box,
  input  logic      prev_takes,   // new box goes at the earlier neighbor or before
  input  box_t      prev_box,     // box of earlier neighbor
  input  logic      prev_vld,
  input  box_t      next_box,     // box of later neighbor (rotation)
  input  logic      next_vld,
  input  logic      next_sup,
  input  logic      sup_hit,      // rotating-in box is suppressed
  output logic      takes,        // new box goes here or before
  output box_t      box,
  output logic      vld,
  output logic      sup
);

  logic here;

  // new box sits before this entry when strictly greater score or slot empty;
  // monotonic along the sorted chain, so no ripple from the head is needed
  assign here  = !vld || (box.sc < new_box.sc);
  assign takes = here;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld <= 1'b0;
      sup <= 1'b0;
    end else if (ctl.insert) begin
      if (prev_takes) begin
        box <= prev_box;
        vld <= prev_vld;
      end else if (here) begin
        box <= new_box;
        vld <= 1'b1;
      end
      sup <= 1'b0;
    end else if (ctl.shift) begin
      box <= next_box;
      vld <= next_vld;
      sup <= next_sup || sup_hit;
    end
  end

endmodule

FILE: design/sfbs_iou.sv
// ----------------------------------------------------------------------------
// sfbs_iou: registered overlap test
// reference box against head box; four stages of multiply and compare
// ----------------------------------------------------------------------------
module sfbs_iou
  import sfbs_pkg::*;
(
  input  logic        clk,
  input  box_t        ref_box,
  input  box_t        cand,
  input  logic [15:0] overlap_limit,
  output logic        hit
);

  logic [COORD_BITS-1:0] ix1, iy1, ix2, iy2;
  logic [AREA_BITS-1:0]  inter, area_a, area_b;
  logic [AREA_BITS+1:0]  uni;
  logic [AREA_BITS+17:0] lhs, lhs_d, rhs;
  logic                  nz;

  assign ix1 = (ref_box.x1 > cand.x1) ? ref_box.x1 : cand.x1;
  assign iy1 = (ref_box.y1 > cand.y1) ? ref_box.y1 : cand.y1;
  assign ix2 = (ref_box.x2 < cand.x2) ? ref_box.x2 : cand.x2;
  assign iy2 = (ref_box.y2 < cand.y2) ? ref_box.y2 : cand.y2;

  always_ff @(posedge clk) begin
    // areas
    inter  <= span_area(ix1, iy1, ix2, iy2);
    area_a <= span_area(ref_box.x1, ref_box.y1, ref_box.x2, ref_box.y2);
    area_b <= span_area(cand.x1, cand.y1, cand.x2, cand.y2);
    // union and scaled intersection
    uni    <= {2'b0, area_a} + {2'b0, area_b} - {2'b0, inter};
    lhs    <= {2'b0, inter, 16'b0};
    // threshold product
    rhs    <= {16'b0, uni} * {{(AREA_BITS+2){1'b0}}, overlap_limit};
    lhs_d  <= lhs;
    nz     <= (uni != '0);
    // compare, zero union never suppresses
    hit    <= nz && (lhs_d > rhs);
  end

endmodule

FILE: design/sfbs_checker.sv
// ----------------------------------------------------------------------------
// sfbs_checker: port-level checks
// handshake and result framing rules seen at the top level ports
// ----------------------------------------------------------------------------
module sfbs_checker
  import sfbs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.none_kept |-> out_data.run_end && out_data.kept_score == '0)
    else $error("empty result");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.none_kept |-> out_data.kept_left == '0)
    else $error("empty box");

endmodule

bind score_filter_box_suppression sfbs_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .out_data
);
